>>> src/rsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite projection package
// Shared types, widths, angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package rsp_pkg;

	localparam int CORDIC_STEPS = 17;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
	localparam int CW           = 34;
	localparam int ZW           = 24;
	localparam int REL_W        = 18;
	localparam int DIST_W       = 23;
	localparam int ISQ_W        = 2 * DIST_W - 1;
	localparam int NUM_W        = 60;
	localparam int DEN_W        = 54;
	localparam int WQ_BITS      = 21;
	localparam int WIDTH_PLANE  = 55;

	typedef logic signed [CW-1:0]    cord_t;
	typedef logic signed [ZW-1:0]    ang_t;
	typedef logic signed [REL_W-1:0] rel_t;

	localparam ang_t  DEG180_Q14 = 24'sd2949120;
	localparam rel_t  DEG180_Q6  = 18'sd11520;
	localparam rel_t  DEG360_Q6  = 18'sd23040;
	localparam logic [13:0] DEG90_Q6 = 14'd5760;
	localparam cord_t CORDIC_X0  = 34'sd652032874;

	function automatic ang_t atan_q14(input int i);
		ang_t a;
		case (i)
			0:  a = 24'sd737280;
			1:  a = 24'sd435242;
			2:  a = 24'sd229970;
			3:  a = 24'sd116736;
			4:  a = 24'sd58595;
			5:  a = 24'sd29326;
			6:  a = 24'sd14667;
			7:  a = 24'sd7334;
			8:  a = 24'sd3667;
			9:  a = 24'sd1833;
			10: a = 24'sd917;
			11: a = 24'sd458;
			12: a = 24'sd229;
			13: a = 24'sd115;
			14: a = 24'sd57;
			15: a = 24'sd29;
			16: a = 24'sd14;
			default: a = '0;
		endcase
		return a;
	endfunction

	function automatic longint unsigned isqrt_c(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		longint unsigned v;
		r = 0;
		b = 64'd1 << 62;
		v = n;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

endpackage

>>> src/rsp_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined CORDIC
// Input register then one micro-rotation per stage; vectoring or rotation.
// ----------------------------------------------------------------------------
module rsp_cordic
	import rsp_pkg::*;
#(
	parameter bit VECTORING = 1'b1
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  cord_t in_x,
	input  cord_t in_y,
	input  ang_t  in_z,
	output logic  out_valid,
	output cord_t out_x,
	output ang_t  out_z
);

	cord_t cx_q [CORDIC_STEPS+1];
	cord_t cy_q [CORDIC_STEPS+1];
	ang_t  cz_q [CORDIC_STEPS+1];
	logic [CORDIC_STEPS:0] cv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q <= '0;
		end else begin
			cv_q <= {cv_q[CORDIC_STEPS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		cx_q[0] <= in_x;
		cy_q[0] <= in_y;
		cz_q[0] <= in_z;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (VECTORING ? cy_q[i][CW-1] : !cz_q[i][ZW-1]) begin
				cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
				cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
				cz_q[i+1] <= cz_q[i] - atan_q14(i);
			end else begin
				cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
				cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
				cz_q[i+1] <= cz_q[i] + atan_q14(i);
			end
		end
	end

	assign out_valid = cv_q[CORDIC_STEPS];
	assign out_x     = cx_q[CORDIC_STEPS];
	assign out_z     = cz_q[CORDIC_STEPS];

endmodule

>>> src/rsp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Overflow check in the first stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module rsp_div
	import rsp_pkg::*;
#(
	parameter int QW = 21
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             out_valid,
	output logic [QW-1:0]    quo,
	output logic             sat
);

	localparam int XW = DEN_W + QW;

	logic [NUM_W-1:0] dr_q [QW+1];
	logic [DEN_W-1:0] dd_q [QW+1];
	logic [QW-1:0]    dq_q [QW+1];
	logic [QW:0]      ds_q;
	logic [QW:0]      dv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q <= '0;
		end else begin
			dv_q <= {dv_q[QW-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		logic [XW-1:0] sub;
		dr_q[0] <= num;
		dd_q[0] <= den;
		dq_q[0] <= '0;
		ds_q[0] <= (XW'(num) >= {den, {QW{1'b0}}});
		for (int k = 0; k < QW; k++) begin
			sub = XW'(dd_q[k]) << (QW - 1 - k);
			if (XW'(dr_q[k]) >= sub) begin
				dr_q[k+1] <= dr_q[k] - sub[NUM_W-1:0];
				dq_q[k+1] <= dq_q[k] | (QW'(1) << (QW - 1 - k));
			end else begin
				dr_q[k+1] <= dr_q[k];
				dq_q[k+1] <= dq_q[k];
			end
			dd_q[k+1] <= dd_q[k];
			ds_q[k+1] <= ds_q[k];
		end
	end

	assign out_valid = dv_q[QW];
	assign quo       = dq_q[QW];
	assign sat       = ds_q[QW];

endmodule

>>> src/raycast_sprite_projection_top.sv
`timescale 1ns / 1ps
// Throughput: one transaction per cycle; busy is never raised.
// The depth is set by the two 17-step CORDIC pipelines, the 23-step square
// root and the 21-bit divider, all in series or in parallel with them.
// arst_n clears every valid stage at once; data stages are not reset.
// ----------------------------------------------------------------------------
// Sprite projection top level
// Distance, bearing, screen columns and projected size of one sprite.
// ----------------------------------------------------------------------------
module raycast_sprite_projection_top
	import rsp_pkg::*;
#(
	parameter int SCREEN_COLUMNS = 640
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [15:0]        viewer_x,
	input  logic [15:0]        viewer_y,
	input  logic signed [15:0] viewer_heading,
	input  logic [15:0]        object_x,
	input  logic [15:0]        object_y,
	output logic               busy,
	output logic               done,
	output logic [22:0]        distance,
	output logic signed [12:0] column_start,
	output logic signed [15:0] column_end,
	output logic [15:0]        projected_height,
	output logic [15:0]        projected_width,
	output logic               not_visible
);

	localparam int SCW  = $clog2(SCREEN_COLUMNS + 1);
	localparam int PW   = 14 + SCW;
	localparam int MW   = PW - 8;
	localparam int MPW  = MW + 13;
	localparam int QSW  = MPW - 16;
	localparam int SVW  = QSW + 3;
	localparam longint unsigned DPP = isqrt_c(3 * SCREEN_COLUMNS * SCREEN_COLUMNS / 4);
	localparam logic [NUM_W-1:0] NUM_H = NUM_W'(64 * DPP) << 42;
	localparam logic [NUM_W-1:0] NUM_WD = NUM_W'(16 * 64 * WIDTH_PLANE) << 42;

	localparam int L_DIST  = 3 + DIST_W;
	localparam int L_AREL  = 22;
	localparam int L_START = L_AREL + 3;
	localparam int L_COS   = L_AREL + CORDIC_LAT;
	localparam int L_DIV   = L_COS + 1 + WQ_BITS + 1;
	localparam int D_DIST  = L_COS - L_DIST;
	localparam int D_START = L_DIV - L_START;
	localparam int D_TAIL  = WQ_BITS + 1;

	assign busy = 1'b0;

	// stage 1: differences
	logic signed [16:0] dx_s1, dy_s1;
	logic signed [15:0] hd_s1;
	logic               v_s1;

	always_ff @(posedge clk) begin
		dx_s1 <= $signed({1'b0, object_x}) - $signed({1'b0, viewer_x});
		dy_s1 <= $signed({1'b0, object_y}) - $signed({1'b0, viewer_y});
		hd_s1 <= viewer_heading;
	end

	// stage 2 and 3: squares, sum
	logic signed [33:0] sqx, sqy;
	logic [32:0]        dxx_s2, dyy_s2;

	assign sqx = dx_s1 * dx_s1;
	assign sqy = dy_s1 * dy_s1;

	always_ff @(posedge clk) begin
		dxx_s2 <= sqx[32:0];
		dyy_s2 <= sqy[32:0];
	end

	// square root, one result bit per stage
	logic [ISQ_W-1:0] isq_n_q [DIST_W+1];
	logic [ISQ_W-1:0] isq_r_q [DIST_W+1];

	always_ff @(posedge clk) begin
		logic [ISQ_W-1:0] bitv;
		logic [ISQ_W:0]   trial;
		isq_n_q[0] <= {(dxx_s2 + dyy_s2), 12'b0};
		isq_r_q[0] <= '0;
		for (int k = 0; k < DIST_W; k++) begin
			bitv  = ISQ_W'(1) << (2 * (DIST_W - 1 - k));
			trial = {1'b0, isq_r_q[k]} + {1'b0, bitv};
			if ({1'b0, isq_n_q[k]} >= trial) begin
				isq_n_q[k+1] <= isq_n_q[k] - trial[ISQ_W-1:0];
				isq_r_q[k+1] <= (isq_r_q[k] >> 1) + bitv;
			end else begin
				isq_n_q[k+1] <= isq_n_q[k];
				isq_r_q[k+1] <= isq_r_q[k] >> 1;
			end
		end
	end

	// bearing: pre-rotate into the right half plane, then vectoring CORDIC
	cord_t bx, by;
	ang_t  bz, bear_z;
	logic  bear_v;

	always_comb begin
		bx = cord_t'(dy_s1) <<< 14;
		by = cord_t'(dx_s1) <<< 14;
		bz = '0;
		if (dy_s1[16]) begin
			bz = dx_s1[16] ? -DEG180_Q14 : DEG180_Q14;
			bx = -bx;
			by = -by;
		end
	end

	rsp_cordic #(.VECTORING(1'b1)) u_bearing (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_x      (bx),
		.in_y      (by),
		.in_z      (bz),
		.out_valid (bear_v),
		.out_x     (),
		.out_z     (bear_z)
	);

	// hold heading and coincidence flag alongside the CORDIC
	logic [16:0] bz_q [CORDIC_LAT];

	always_ff @(posedge clk) begin
		bz_q[0] <= {(dx_s1 == '0) && (dy_s1 == '0), hd_s1};
		for (int k = 1; k < CORDIC_LAT; k++) begin
			bz_q[k] <= bz_q[k-1];
		end
	end

	// stage 20: round bearing, subtract heading
	ang_t zr;
	rel_t bear_r;
	rel_t rel_raw_s20;
	rel_t rel_s21;
	rel_t relw;
	logic v_s20, v_s21, v_s22;

	always_comb begin
		zr     = (bear_z + 24'sd128) >>> 8;
		bear_r = bz_q[CORDIC_LAT-1][16] ? '0 : REL_W'(zr);
	end

	always_ff @(posedge clk) begin
		rel_raw_s20 <= bear_r - rel_t'($signed(bz_q[CORDIC_LAT-1][15:0]));
	end

	// stage 21: wrap into half a turn either side
	always_comb begin
		relw = rel_raw_s20;
		if (relw > DEG180_Q6) begin
			relw = relw - DEG360_Q6;
		end
		if (relw > DEG180_Q6) begin
			relw = relw - DEG360_Q6;
		end
		if (relw < -DEG180_Q6) begin
			relw = relw + DEG360_Q6;
		end
		if (relw < -DEG180_Q6) begin
			relw = relw + DEG360_Q6;
		end
	end

	always_ff @(posedge clk) begin
		rel_s21 <= relw;
	end

	// stage 22: magnitude and column product
	rel_t          absr;
	logic [13:0]   arel_s22;
	logic          neg_s22;
	logic [PW-1:0] prod_s22;

	assign absr = rel_s21[REL_W-1] ? -rel_s21 : rel_s21;

	always_ff @(posedge clk) begin
		arel_s22 <= absr[13:0];
		neg_s22  <= rel_s21[REL_W-1];
		prod_s22 <= PW'(absr[13:0]) * PW'(SCREEN_COLUMNS);
	end

	// start column: divide by 3840 as shift and reciprocal of 15
	logic [MW-1:0]  m_s23;
	logic [MPW-1:0] mp_s23;
	logic           neg_s23, neg_s24;
	logic [QSW-1:0] q0, q_s24;
	logic [MW-1:0]  rem;
	logic signed [SVW-1:0] sv;
	logic signed [12:0]    start_s25;

	always_ff @(posedge clk) begin
		m_s23   <= prod_s22[PW-1:8];
		mp_s23  <= MPW'(prod_s22[PW-1:8]) * MPW'(13'd4369);
		neg_s23 <= neg_s22;
	end

	assign q0  = mp_s23[MPW-1:16];
	assign rem = m_s23 - MW'(q0) * MW'(4'd15);

	always_ff @(posedge clk) begin
		q_s24   <= (rem >= MW'(4'd15)) ? q0 + QSW'(1) : q0;
		neg_s24 <= neg_s23;
	end

	always_comb begin
		sv = neg_s24 ? SVW'(320) - $signed({1'b0, q_s24})
			: SVW'(320) + $signed({1'b0, q_s24});
	end

	always_ff @(posedge clk) begin
		if (sv > SVW'(4095)) begin
			start_s25 <= 13'sd4095;
		end else if (sv < -SVW'(4096)) begin
			start_s25 <= -13'sd4096;
		end else begin
			start_s25 <= sv[12:0];
		end
	end

	// cosine by rotation CORDIC
	cord_t cos_x;
	ang_t  cos_z;
	logic  cos_v;

	assign cos_z = ang_t'({2'b00, arel_s22, 8'b0});

	rsp_cordic #(.VECTORING(1'b0)) u_cosine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s22),
		.in_x      (CORDIC_X0),
		.in_y      ('0),
		.in_z      (cos_z),
		.out_valid (cos_v),
		.out_x     (cos_x),
		.out_z     ()
	);

	logic              inr_q  [CORDIC_LAT];
	logic [DIST_W-1:0] dist_q [D_DIST];
	logic [12:0]       start_q [D_START];

	always_ff @(posedge clk) begin
		inr_q[0]   <= arel_s22 < DEG90_Q6;
		dist_q[0]  <= isq_r_q[DIST_W][DIST_W-1:0];
		start_q[0] <= start_s25;
		for (int k = 1; k < CORDIC_LAT; k++) begin
			inr_q[k] <= inr_q[k-1];
		end
		for (int k = 1; k < D_DIST; k++) begin
			dist_q[k] <= dist_q[k-1];
		end
		for (int k = 1; k < D_START; k++) begin
			start_q[k] <= start_q[k-1];
		end
	end

	// stage 41: denominator and visibility
	logic [DEN_W-1:0]  den_s41;
	logic              hid_s41;
	logic [DIST_W-1:0] dist_s41;
	logic              v_s41;
	logic [DIST_W-1:0] dist40;

	assign dist40 = dist_q[D_DIST-1];

	always_ff @(posedge clk) begin
		den_s41  <= dist40 * cos_x[30:0];
		hid_s41  <= !inr_q[CORDIC_LAT-1] || cos_x[CW-1] || (cos_x == '0)
			|| (dist40 == '0);
		dist_s41 <= dist40;
	end

	logic [WQ_BITS-1:0] qh, qw;
	logic               sh, sw, div_v;

	rsp_div #(.QW(WQ_BITS)) u_div_h (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s41),
		.num       (NUM_H),
		.den       (den_s41),
		.out_valid (),
		.quo       (qh),
		.sat       (sh)
	);

	rsp_div #(.QW(WQ_BITS)) u_div_w (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s41),
		.num       (NUM_WD),
		.den       (den_s41),
		.out_valid (div_v),
		.quo       (qw),
		.sat       (sw)
	);

	logic [DIST_W:0] tail_q [D_TAIL];

	always_ff @(posedge clk) begin
		tail_q[0] <= {hid_s41, dist_s41};
		for (int k = 1; k < D_TAIL; k++) begin
			tail_q[k] <= tail_q[k-1];
		end
	end

	// output stage
	logic               hid63;
	logic signed [12:0] start63;
	logic [16:0]        w16;
	logic signed [18:0] esum;
	logic [15:0]        hq_n, wq_n;
	logic signed [15:0] end_n;

	assign hid63   = tail_q[D_TAIL-1][DIST_W];
	assign start63 = $signed(start_q[D_START-1]);
	assign w16     = qw[WQ_BITS-1:4];
	assign esum    = 19'(start63) + $signed({2'b00, w16});

	always_comb begin
		hq_n  = (hid63 || sh || (qh[WQ_BITS-1:16] != '0)) ? 16'hFFFF : qh[15:0];
		wq_n  = (hid63 || sw || (qw[WQ_BITS-1:16] != '0)) ? 16'hFFFF : qw[15:0];
		if (hid63 || sw || (w16 > 17'd70000) || (esum > 19'sd32767)) begin
			end_n = 16'sh7FFF;
		end else if (esum < -19'sd32768) begin
			end_n = -16'sh8000;
		end else begin
			end_n = esum[15:0];
		end
	end

	always_ff @(posedge clk) begin
		distance         <= tail_q[D_TAIL-1][DIST_W-1:0];
		column_start     <= start63;
		column_end       <= end_n;
		projected_height <= hq_n;
		projected_width  <= wq_n;
		not_visible      <= hid63;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s20 <= 1'b0;
			v_s21 <= 1'b0;
			v_s22 <= 1'b0;
			v_s41 <= 1'b0;
			done  <= 1'b0;
		end else begin
			v_s1  <= start;
			v_s20 <= bear_v;
			v_s21 <= v_s20;
			v_s22 <= v_s21;
			v_s41 <= cos_v;
			done  <= div_v;
		end
	end

endmodule

>>> src/rsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite projection port checker
// Transaction timing and result consistency seen at the top-level ports.
// ----------------------------------------------------------------------------
module rsp_checker #(
	parameter int LATENCY = 64
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [22:0]        distance,
	input logic signed [12:0] column_start,
	input logic signed [15:0] column_end,
	input logic [15:0]        projected_height,
	input logic [15:0]        projected_width,
	input logic               not_visible
);

	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted transaction gave no result");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without accepted transaction");

	a_hidden_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && not_visible) |-> (projected_height == 16'hFFFF
			&& projected_width == 16'hFFFF && column_end == 16'sh7FFF))
		else $error("hidden sprite sizes not saturated");

	a_visible_geom: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !not_visible) |-> (distance != 23'd0 && column_end >= column_start))
		else $error("visible sprite geometry inconsistent");

endmodule

bind raycast_sprite_projection_top rsp_checker #(.LATENCY(64)) u_rsp_checker (.*);
